[rtl/core/vad_pkg.sv]
package vad_pkg;

  // Algorithm configuration
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;

  // Field widths
  localparam int VEC_W   = 32;
  localparam int CORR_W  = 26;
  localparam int ANGLE_W = 27;

  // Datapath widths: |x|,|y| <= 2^31, CORDIC gain < 2.33 after folding
  localparam int XY_W     = VEC_W + 3;
  localparam int ANG_FRAC = 32;
  localparam int ZW       = ANG_FRAC + 10;
  localparam int SH       = ANG_FRAC - FRAC_BITS;
  localparam int DW       = ((FRAC_BITS + 10 > ANGLE_W) ? FRAC_BITS + 10 : ANGLE_W) + 1;

  localparam logic signed [ZW-1:0] DEG90_Z  = ZW'(longint'(90) << ANG_FRAC);
  localparam logic signed [ZW-1:0] DEG180_Z = ZW'(longint'(180) << ANG_FRAC);
  localparam logic signed [ZW-1:0] ROUND_Z  = ZW'(longint'(1) << (SH - 1));
  localparam logic signed [DW-1:0] DEG360_D = DW'(longint'(360) << FRAC_BITS);

  // atan(2^-i) in degrees, scaled by 2^32
  localparam logic signed [ZW-1:0] ATAN_TABLE [32] = '{
    42'sd193273528320, 42'sd114096026022, 42'sd60285206653, 42'sd30601712202,
    42'sd15360239181,  42'sd7687607525,   42'sd3844741810,  42'sd1922488225,
    42'sd961258780,    42'sd480631223,    42'sd240315841,   42'sd120157949,
    42'sd60078978,     42'sd30039489,     42'sd15019745,    42'sd7509872,
    42'sd3754936,      42'sd1877468,      42'sd938734,      42'sd469367,
    42'sd234684,       42'sd117342,       42'sd58671,       42'sd29335,
    42'sd14668,        42'sd7334,         42'sd3667,        42'sd1833,
    42'sd917,          42'sd458,          42'sd229,         42'sd115
  };

  // Side information that travels with each item down the pipeline
  typedef struct packed {
    logic                     xneg;
    logic                     yneg;
    logic                     ax_zero;
    logic                     ay_zero;
    logic signed [CORR_W-1:0] corr;
  } vad_meta_t;

endpackage

[rtl/core/vad_if.sv]
interface vad_vec_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vad_pkg::VEC_W-1:0]     vec_x;
  logic signed [vad_pkg::VEC_W-1:0]     vec_y;
  logic signed [vad_pkg::CORR_W-1:0]    correction_deg;

  modport source (output valid, output vec_x, output vec_y, output correction_deg,
                  input ready);
  modport sink (input valid, input vec_x, input vec_y, input correction_deg,
                output ready);
endinterface

interface vad_angle_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vad_pkg::ANGLE_W-1:0]   angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);
endinterface

[rtl/core/vector_angle_degrees.sv]
// Channel  Dir  Payload                                Handshake
// vec      in   vec_x, vec_y (Q16.16), correction_deg   valid/ready, item taken when both high
// angle    out  angle_deg (Q11.16 degrees, 27 bits)     valid/ready, item taken when both high
//
// One item per cycle sustained while angle.ready stays high; a result shows on
// angle after its item passes one input register, one register per CORDIC rotation (16),
// then quadrant fix, rounding, and correction/wrap stages.
// rst (synchronous) clears only the stage valid bits.
// Every stage holds its item until the next stage has room; empty stages fill
// even while the output stalls, so no item is lost or repeated.
module vector_angle_degrees (
  input  logic               clk,
  input  logic               rst,
  vad_vec_if.sink            vec,
  vad_angle_if.source        angle
);

  localparam int N  = vad_pkg::CORDIC_STAGES;
  localparam int NS = N + 4;

  // Stage map: 0 input fold, 1..N rotations, N+1 quadrant, N+2 round, N+3 output
  logic vld [NS];
  logic rdy [NS];

  logic signed [vad_pkg::XY_W-1:0] x [N+1];
  logic signed [vad_pkg::XY_W-1:0] y [N+1];
  logic signed [vad_pkg::ZW-1:0]   z [1:N];
  vad_pkg::vad_meta_t              meta [N+3];

  logic signed [vad_pkg::ZW-1:0]      ang;
  logic signed [vad_pkg::DW-1:0]      rnd;
  logic signed [vad_pkg::ANGLE_W-1:0] out_deg;

  // A stage may load when it is empty or its item moves on this cycle
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || angle.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vec.ready   = rdy[0];
  assign angle.valid = vld[NS-1];
  assign angle.angle_deg = out_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld[0] <= vec.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input stage: fold the vector into the first quadrant and note the axes
  logic signed [vad_pkg::XY_W-1:0] vx_ext;
  logic signed [vad_pkg::XY_W-1:0] vy_ext;

  assign vx_ext = vad_pkg::XY_W'(vec.vec_x);
  assign vy_ext = vad_pkg::XY_W'(vec.vec_y);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x[0]         <= vec.vec_x[vad_pkg::VEC_W-1] ? -vx_ext : vx_ext;
      y[0]         <= vec.vec_y[vad_pkg::VEC_W-1] ? -vy_ext : vy_ext;
      meta[0].xneg    <= vec.vec_x[vad_pkg::VEC_W-1];
      meta[0].yneg    <= vec.vec_y[vad_pkg::VEC_W-1];
      meta[0].ax_zero <= (vec.vec_x == '0);
      meta[0].ay_zero <= (vec.vec_y == '0);
      meta[0].corr    <= vec.correction_deg;
    end
  end

  // Rotation stages: drive y toward zero, accumulate the angle
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [vad_pkg::ZW-1:0] z_cur;

    if (i == 0) begin : g_first
      assign z_cur = '0;
    end else begin : g_rest
      assign z_cur = z[i];
    end

    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        if (!y[i][vad_pkg::XY_W-1]) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z_cur + vad_pkg::ATAN_TABLE[i];
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z_cur - vad_pkg::ATAN_TABLE[i];
        end
        meta[i+1] <= meta[i];
      end
    end
  end : g_rot

  // Quadrant stage: exact axis angles, then restore quadrant and sign
  logic signed [vad_pkg::ZW-1:0] a_sel;
  logic signed [vad_pkg::ZW-1:0] a_base;
  logic signed [vad_pkg::ZW-1:0] a_term;

  always_comb begin
    priority if (meta[N].ay_zero) begin
      a_sel = '0;
    end else if (meta[N].ax_zero) begin
      a_sel = vad_pkg::DEG90_Z;
    end else begin
      a_sel = z[N];
    end

    // x<0: 180 - a; y<0 negates the whole angle
    if (meta[N].xneg) begin
      a_base = meta[N].yneg ? -vad_pkg::DEG180_Z : vad_pkg::DEG180_Z;
    end else begin
      a_base = '0;
    end
    a_term = (meta[N].xneg ^ meta[N].yneg) ? -a_sel : a_sel;
  end

  always_ff @(posedge clk) begin
    if (rdy[N+1]) begin
      ang       <= a_base + a_term;
      meta[N+1] <= meta[N];
    end
  end

  // Round half up to the output fraction width
  always_ff @(posedge clk) begin
    if (rdy[N+2]) begin
      rnd       <= vad_pkg::DW'((ang + vad_pkg::ROUND_Z) >>> vad_pkg::SH);
      meta[N+2] <= meta[N+1];
    end
  end

  // Subtract the correction, wrap once by 360 if negative
  logic signed [vad_pkg::DW-1:0] diff;
  logic signed [vad_pkg::DW-1:0] wrapped;

  always_comb begin
    diff    = rnd - vad_pkg::DW'(meta[N+2].corr);
    wrapped = diff[vad_pkg::DW-1] ? diff + vad_pkg::DEG360_D : diff;
  end

  always_ff @(posedge clk) begin
    if (rdy[N+3]) begin
      out_deg <= wrapped[vad_pkg::ANGLE_W-1:0];
    end
  end

endmodule

[dv/vector_angle_degrees_tb.sv]
module vector_angle_degrees_tb;

  // Field widths come from the package so the items match the ports exactly.
  localparam int VEC_W   = vad_pkg::VEC_W;
  localparam int CORR_W  = vad_pkg::CORR_W;
  localparam int ANGLE_W = vad_pkg::ANGLE_W;
  localparam int FRAC    = vad_pkg::FRAC_BITS;
  localparam int STAGES  = vad_pkg::CORDIC_STAGES;

  // Angles inside the predictor carry 32 fraction bits; the result keeps FRAC.
  localparam int Q_ANG       = 32;
  localparam int ROUND_SHIFT = Q_ANG - FRAC;

  // Legal correction range is +-360 degrees in Q16.16.
  localparam int CORR_LIMIT = 360 << FRAC;

  // Give the pipeline generous slack before calling the run done.
  localparam int DRAIN_CYCLES = 60;
  // Stretch during which the receiver refuses results, long enough to back
  // the whole pipeline up into the input.
  localparam int HOLDOFF_CYCLES = 150;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 3000;

  // atan(2^-i) in degrees, Q32 fraction.
  localparam longint ATAN_DEG_Q32 [32] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239181,  64'sd7687607525,   64'sd3844741810,  64'sd1922488225,
    64'sd961258780,    64'sd480631223,    64'sd240315841,   64'sd120157949,
    64'sd60078978,     64'sd30039489,     64'sd15019745,    64'sd7509872,
    64'sd3754936,      64'sd1877468,      64'sd938734,      64'sd469367,
    64'sd234684,       64'sd117342,       64'sd58671,       64'sd29335,
    64'sd14668,        64'sd7334,         64'sd3667,        64'sd1833,
    64'sd917,          64'sd458,          64'sd229,         64'sd115
  };

  typedef struct {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [CORR_W-1:0] corr;
  } vec_item_t;

  logic clk = 1'b0;
  logic rst;

  vad_vec_if   vec_ch ();
  vad_angle_if angle_ch ();

  vector_angle_degrees DUT (
    .clk   (clk),
    .rst   (rst),
    .vec   (vec_ch),
    .angle (angle_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Vectors waiting to be offered, and angles waiting to come back.
  vec_item_t                   vector_backlog [$];
  logic signed [ANGLE_W-1:0]   expected_angles [$];

  // Idle rates in percent, and a phase marker that is 0 until phase 2 begins, then 2.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_sel     = 0;

  logic vec_taken = 1'b0;
  int   fail_count  = 0;
  int   holdoff_left = 0;
  logic holdoff_done = 1'b0;

  // -------------------------------------------------------------------------
  // Predictor: four-quadrant angle in degrees minus the correction, one wrap.
  // Fold to the first quadrant, rotate toward the x axis, then restore the
  // quadrant and sign, round half up to FRAC bits, subtract, wrap once.
  // -------------------------------------------------------------------------
  function automatic logic signed [ANGLE_W-1:0] atan2_degrees(
    logic signed [VEC_W-1:0] vx, logic signed [VEC_W-1:0] vy,
    logic signed [CORR_W-1:0] corr);
    longint sx, sy, ax, ay, rx, ry, z, dx, dy, ang, deg;
    int     i;
    sx = longint'(vx);
    sy = longint'(vy);
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    if (sx == 0 && sy == 0) begin
      ang = 0;
    end else begin
      // Exact axis results bypass the rotations.
      if (ay == 0) begin
        z = 0;
      end else if (ax == 0) begin
        z = longint'(90) <<< Q_ANG;
      end else begin
        rx = ax;
        ry = ay;
        z  = 0;
        for (i = 0; i < STAGES && i < 32; i++) begin
          dx = ry >>> i;
          dy = rx >>> i;
          if (ry >= 0) begin
            rx = rx + dx;
            ry = ry - dy;
            z  = z + ATAN_DEG_Q32[i];
          end else begin
            rx = rx - dx;
            ry = ry + dy;
            z  = z - ATAN_DEG_Q32[i];
          end
        end
      end
      if (sx < 0) z = (longint'(180) <<< Q_ANG) - z;
      ang = (sy < 0) ? -z : z;
    end
    deg = (ang + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    deg = deg - longint'(corr);
    if (deg < 0) deg = deg + (longint'(360) <<< FRAC);
    return deg[ANGLE_W-1:0];
  endfunction

  task automatic queue_vector(int x, int y, int c);
    vec_item_t it;
    it.vx   = x;
    it.vy   = y;
    it.corr = c[CORR_W-1:0];
    vector_backlog.push_back(it);
  endtask

  // Random magnitude spread over all scales, with a random sign.
  function automatic int scaled_value();
    int v;
    v = int'($urandom >> $urandom_range(31, 0));
    return ($urandom_range(1, 0) == 1) ? -v : v;
  endfunction

  // Mix of shapes: full-range noise, small and mixed-scale vectors, axis
  // hits, extremes, and near-diagonal pairs that stress the last rotations.
  function automatic vec_item_t random_vector();
    vec_item_t it;
    int        pick, m, c;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      it.vx = $urandom;
      it.vy = $urandom;
    end else if (pick < 60) begin
      it.vx = scaled_value();
      it.vy = scaled_value();
    end else if (pick < 72) begin
      // One component zero, sometimes both.
      m = scaled_value();
      case ($urandom_range(4, 0))
        0: begin it.vx = 0; it.vy = m; end
        1: begin it.vx = m; it.vy = 0; end
        2: begin it.vx = 0; it.vy = 0; end
        3: begin it.vx = -(m & 32'h7fff_ffff) - 1; it.vy = 0; end
        default: begin it.vx = 0; it.vy = $urandom; end
      endcase
    end else if (pick < 85) begin
      case ($urandom_range(5, 0))
        0: it.vx = 32'h8000_0000;
        1: it.vx = 32'h7fff_ffff;
        2: it.vx = 1;
        3: it.vx = -1;
        4: it.vx = 0;
        default: it.vx = $urandom;
      endcase
      case ($urandom_range(5, 0))
        0: it.vy = 32'h8000_0000;
        1: it.vy = 32'h7fff_ffff;
        2: it.vy = 1;
        3: it.vy = -1;
        4: it.vy = 0;
        default: it.vy = $urandom;
      endcase
    end else begin
      m     = scaled_value();
      it.vx = m;
      it.vy = m + $urandom_range(15, 0) - 8;
      if ($urandom_range(1, 0) == 1) it.vy = -it.vy;
    end
    pick = $urandom_range(99, 0);
    if (pick < 85) begin
      c = int'($urandom_range(2 * CORR_LIMIT, 0)) - CORR_LIMIT;
    end else if (pick < 95) begin
      case ($urandom_range(2, 0))
        0: c = CORR_LIMIT;
        1: c = -CORR_LIMIT;
        default: c = 0;
      endcase
    end else begin
      // Any 26-bit pattern, often out of the legal range.
      c = $urandom;
    end
    it.corr = c[CORR_W-1:0];
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Vector driver: change on the falling edge; keep an item steady until it
  // is taken, then drop it from the backlog and offer the next one (or idle).
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      vec_ch.valid <= 1'b0;
    end else begin
      if (vec_taken) void'(vector_backlog.pop_front());
      if (!vec_ch.valid || vec_taken) begin
        if (vector_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          vec_ch.valid          <= 1'b1;
          vec_ch.vec_x          <= vector_backlog[0].vx;
          vec_ch.vec_y          <= vector_backlog[0].vy;
          vec_ch.correction_deg <= vector_backlog[0].corr;
        end else begin
          vec_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: random ready, plus one long hold-off at the start of the
  // last phase so the pipeline fills and must stall its input.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      angle_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      angle_ch.ready <= 1'b0;
      holdoff_left   <= holdoff_left - 1;
    end else if (phase_sel == 2 && !holdoff_done) begin
      angle_ch.ready <= 1'b0;
      holdoff_left   <= HOLDOFF_CYCLES - 1;
      holdoff_done   <= 1'b1;
    end else begin
      angle_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: on each rising edge check the outgoing angle against the oldest
  // prediction first, then predict for any vector taken on this edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic signed [ANGLE_W-1:0] want;
    vec_taken <= !rst && vec_ch.valid && vec_ch.ready;
    if (!rst && angle_ch.valid && angle_ch.ready) begin
      if (expected_angles.size() == 0) begin
        $error("angle_deg: unexpected item, expected none, actual %0d", angle_ch.angle_deg);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_angles.pop_front();
        if (angle_ch.angle_deg !== want) begin
          $error("angle_deg: expected %0d, actual %0d", want, angle_ch.angle_deg);
          fail_count <= fail_count + 1;
        end
      end
    end
    if (!rst && vec_ch.valid && vec_ch.ready)
      expected_angles.push_back(atan2_degrees(vec_ch.vec_x, vec_ch.vec_y,
                                              vec_ch.correction_deg));
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (vec_ch.valid && vec_ch.ready) || (angle_ch.valid && angle_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** vector_angle_degrees: FAILED **");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: reset, directed corner vectors, then three random phases with
  // different idle mixes; drain and report.
  // -------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    vec_ch.valid          = 1'b0;
    vec_ch.vec_x          = '0;
    vec_ch.vec_y          = '0;
    vec_ch.correction_deg = '0;
    angle_ch.ready        = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 0: sender mostly busy, receiver mostly stalled.
    send_idle_pct = 18;
    recv_idle_pct = 77;

    // Zero vector, with and without correction.
    queue_vector(0, 0, 0);
    queue_vector(0, 0, CORR_LIMIT);
    // Axes: negative x gives +180, the others are exact.
    queue_vector(-65536, 0, 0);
    queue_vector(65536, 0, 0);
    queue_vector(0, 65536, 0);
    queue_vector(0, -65536, 0);
    queue_vector(32'h8000_0000, 0, 0);
    queue_vector(0, 32'h8000_0000, 0);
    // Extremes of both components, all quadrants.
    queue_vector(32'h8000_0000, 32'h8000_0000, 0);
    queue_vector(32'h7fff_ffff, 32'h7fff_ffff, 0);
    queue_vector(32'h7fff_ffff, 32'h8000_0000, 0);
    queue_vector(32'h8000_0000, 32'h7fff_ffff, 0);
    queue_vector(1, 1, 0);
    queue_vector(-1, -1, 0);
    queue_vector(-1, 1, 0);
    // Just either side of the negative x axis.
    queue_vector(-65536, 1, 0);
    queue_vector(-65536, -1, 0);
    // Correction extremes, with and without the wrap.
    queue_vector(65536, -65536, CORR_LIMIT);
    queue_vector(65536, 65536, -CORR_LIMIT);
    queue_vector(100, 0, -CORR_LIMIT);
    queue_vector(0, 0, -CORR_LIMIT);
    queue_vector(-5, 0, -CORR_LIMIT);
    // Correction beyond the legal range is still subtracted.
    queue_vector(3, 7, 32'h01ff_ffff);
    queue_vector(3, -7, 32'h0200_0000);

    repeat (260) vector_backlog.push_back(random_vector());
    while (vector_backlog.size() != 0) @(posedge clk);

    // Phase 1: the other way round.
    send_idle_pct = 77;
    recv_idle_pct = 18;
    repeat (270) vector_backlog.push_back(random_vector());
    while (vector_backlog.size() != 0) @(posedge clk);

    // Phase 2: no idling, opened by the long receiver hold-off.
    repeat (270) vector_backlog.push_back(random_vector());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_sel     = 2;
    while (vector_backlog.size() != 0 || expected_angles.size() != 0) @(posedge clk);

    // Let any stray result surface before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_angles.size() == 0) begin
      $display("** vector_angle_degrees: PASSED **");
    end else begin
      $display("** vector_angle_degrees: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/vad_pkg.sv
rtl/core/vad_if.sv
rtl/core/vector_angle_degrees.sv
dv/vector_angle_degrees_tb.sv
